// ===== hdl/dcki_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcki_pkg: shared types and constants for the dyadic cover key index core
// Tree height, register indexes and the per-level pipeline word.
// ----------------------------------------------------------------------------
package dcki_pkg;

    localparam int TREE_HEIGHT = 64;
    localparam int NUM_LVL     = TREE_HEIGHT + 1;
    localparam int IDX_W       = 10;

    localparam logic [63:0] TREE_MASK =
        (TREE_HEIGHT >= 64) ? {64{1'b1}} : ((64'd1 << TREE_HEIGHT) - 64'd1);

    localparam logic [1:0] REG_WINDOW_START    = 2'd0;
    localparam logic [1:0] REG_WINDOW_END      = 2'd1;
    localparam logic [1:0] REG_COVER_KEY_COUNT = 2'd2;

    typedef struct packed {
        logic [63:0]             lo;
        logic [63:0]             hi;
        logic [63:0]             t;
        logic signed [IDX_W-1:0] lo_idx;
        logic signed [IDX_W-1:0] hi_idx;
        logic                    done;
        logic                    hit;
        logic signed [IDX_W-1:0] idx;
        logic [6:0]              lvl;
    } stage_t;

endpackage

// ===== hdl/dyadic_cover_key_index_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dyadic_cover_key_index_core: timestamp to cover key lookup
// Finds the node of a window's canonical binary-tree cover that holds a
// timestamp and reports its key index, prefix and level.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   window_start, window_end and cover_key_count; cfg_ready is always high.
//   Write configuration only while no word is in flight.
//   ts channel (ts_valid/ts_stall, timestamp) carries one timestamp per word;
//   res channel (res_valid/res_stall, found, key_index, node_prefix,
//   node_level) returns one result word per timestamp, in order.
//   The pipeline has one range check stage loaded at the accepting
//   edge, one stage per tree level from leaf up to root and one output
//   stage. Throughput is one word per cycle while no stalled result
//   holds the pipeline; each level stage does the odd-start check, the
//   even-end check and the shift for its level.
//   A stalled result freezes the whole pipeline and raises ts_stall in the
//   same cycle; nothing is dropped or repeated.
//   Reset empties the pipeline and sets the window to [0, 0] with one key.
// ----------------------------------------------------------------------------
module dyadic_cover_key_index_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        ts_valid,
    output logic        ts_stall,
    input  logic [63:0] timestamp,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        found,
    output logic [6:0]  key_index,
    output logic [63:0] node_prefix,
    output logic [6:0]  node_level
);

    logic [63:0] win_start_reg;
    logic [63:0] win_end_reg;
    logic [7:0]  key_cnt_reg;

    dcki_pkg::stage_t stg_reg  [0:dcki_pkg::NUM_LVL];
    dcki_pkg::stage_t stg_next [0:dcki_pkg::NUM_LVL];
    logic             vld_reg  [0:dcki_pkg::NUM_LVL];

    logic        res_valid_reg;
    logic        found_reg;
    logic [6:0]  key_index_reg;
    logic [63:0] node_prefix_reg;
    logic [6:0]  node_level_reg;

    logic        found_next;
    logic        adv;

    dcki_pkg::stage_t setup;
    dcki_pkg::stage_t last;

    // one tree level: odd start node, even end node, then climb
    function automatic dcki_pkg::stage_t lvl_step(dcki_pkg::stage_t s, logic [6:0] lvl);
        dcki_pkg::stage_t r;
        r = s;
        if (!r.done) begin
            if (r.lo_idx > r.hi_idx) begin
                r.done = 1'b1;
            end else if (r.lo[0]) begin
                if (r.lo == r.t) begin
                    r.done = 1'b1;
                    r.hit  = 1'b1;
                    r.idx  = r.lo_idx;
                    r.lvl  = lvl;
                end else begin
                    r.lo     = r.lo + 64'd1;
                    r.lo_idx = r.lo_idx + dcki_pkg::IDX_W'(1);
                end
            end
        end
        if (!r.done) begin
            if (r.lo_idx > r.hi_idx) begin
                r.done = 1'b1;
            end else if (!r.hi[0]) begin
                if (r.hi == r.t) begin
                    r.done = 1'b1;
                    r.hit  = 1'b1;
                    r.idx  = r.hi_idx;
                    r.lvl  = lvl;
                end else begin
                    r.hi     = r.hi - 64'd1;
                    r.hi_idx = r.hi_idx - dcki_pkg::IDX_W'(1);
                end
            end
        end
        if (!r.done) begin
            if (r.lo_idx > r.hi_idx) begin
                r.done = 1'b1;
            end else begin
                r.lo = r.lo >> 1;
                r.hi = r.hi >> 1;
                r.t  = r.t >> 1;
            end
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign adv       = !(res_valid_reg && res_stall);
    assign ts_stall  = !adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= '0;
            win_end_reg   <= '0;
            key_cnt_reg   <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dcki_pkg::REG_WINDOW_START:    win_start_reg <= cfg_data;
                dcki_pkg::REG_WINDOW_END:      win_end_reg   <= cfg_data;
                dcki_pkg::REG_COVER_KEY_COUNT: key_cnt_reg   <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    // range check and walk setup
    always_comb
    begin
        setup.t      = timestamp & dcki_pkg::TREE_MASK;
        setup.lo     = win_start_reg & dcki_pkg::TREE_MASK;
        setup.hi     = win_end_reg & dcki_pkg::TREE_MASK;
        setup.lo_idx = '0;
        setup.hi_idx = $signed({2'b00, key_cnt_reg}) - dcki_pkg::IDX_W'(1);
        setup.done   = (setup.t < setup.lo) || (setup.t > setup.hi);
        setup.hit    = 1'b0;
        setup.idx    = '0;
        setup.lvl    = '0;
    end

    assign stg_next[0] = setup;

    genvar k;
    generate
        for (k = 0; k < dcki_pkg::NUM_LVL; k++)
        begin : g_lvl
            assign stg_next[k+1] = lvl_step(stg_reg[k], 7'(dcki_pkg::TREE_HEIGHT - k));
        end

        for (k = 0; k <= dcki_pkg::NUM_LVL; k++)
        begin : g_stg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[k] <= (k == 0) ? ts_valid : vld_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end
        end
    endgenerate

    // past the root nothing more can match
    assign last       = stg_reg[dcki_pkg::NUM_LVL];
    assign found_next = last.done && last.hit && (last.idx >= 0) &&
                        (last.idx <= dcki_pkg::IDX_W'(127)) &&
                        (last.idx < $signed({2'b00, key_cnt_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= vld_reg[dcki_pkg::NUM_LVL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg       <= found_next;
            key_index_reg   <= found_next ? last.idx[6:0] : 7'd0;
            node_prefix_reg <= found_next ? last.t : 64'd0;
            node_level_reg  <= found_next ? last.lvl : 7'd0;
        end
    end

    assign res_valid   = res_valid_reg;
    assign found       = found_reg;
    assign key_index   = key_index_reg;
    assign node_prefix = node_prefix_reg;
    assign node_level  = node_level_reg;

    // accepted word lands in the setup stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        ts_valid && !ts_stall |=> vld_reg[0])
        else $error("accepted word missing from setup stage");

    // a held result freezes the last level stage
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(vld_reg[dcki_pkg::NUM_LVL]))
        else $error("pipeline moved under stall");

    // not-found results carry zero fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> (key_index == 7'd0) && (node_prefix == 64'd0) &&
                                (node_level == 7'd0))
        else $error("not-found result has nonzero fields");

    // a node never sits below the leaves
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && found |-> node_level <= 7'(dcki_pkg::TREE_HEIGHT))
        else $error("node level beyond tree height");

endmodule
